// File: rtl/core/cdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared constants, types and table functions for the calendar date pipeline.
// ----------------------------------------------------------------------------
package cdc_pkg;

	localparam int unsigned YEAR_MAX_DEF = 9999;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DIST_W  = 22;
	localparam int WDAY_W  = 3;
	localparam int ORD_W   = 23;   // ordinal day number of any 14-bit year
	localparam int QUO_W   = 8;    // year / 100
	localparam int ZSUM_W  = 11;   // Zeller sum before mod 7
	localparam int IN_W    = 48;
	localparam int OUT_W   = 32;

	// floor(x / 100) = (x * RECIP100) >> RECIP_SH, exact for x < 43690
	localparam logic [12:0] RECIP100 = 13'd5243;
	localparam int          RECIP_SH = 19;
	localparam int          PROD_W   = YEAR_W + 13;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
	localparam logic [MONTH_W-1:0] MONTHS  = 4'd12;

	localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd0;

	// stage load enables and handshake outputs of the valid chain
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
		logic in_ready;
		logic out_valid;
	} cdc_ctl_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// floor(13 * (m + 1) / 5) for the shifted month 3..14
	function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
		logic [5:0] z;
		case (m)
			4'd3:    z = 6'd10;
			4'd4:    z = 6'd13;
			4'd5:    z = 6'd15;
			4'd6:    z = 6'd18;
			4'd7:    z = 6'd20;
			4'd8:    z = 6'd23;
			4'd9:    z = 6'd26;
			4'd10:   z = 6'd28;
			4'd11:   z = 6'd31;
			4'd12:   z = 6'd33;
			4'd13:   z = 6'd36;
			4'd14:   z = 6'd39;
			default: z = 6'd0;
		endcase
		return z;
	endfunction

	// 8 = 1 mod 7, so octal digits fold
	function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] x);
		logic [4:0] f1;
		logic [3:0] f2;
		logic [2:0] f3;
		f1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[10:9]);
		f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
		f3 = f2[2:0] + 3'(f2[3]);
		return (f3 == 3'd7) ? 3'd0 : f3;
	endfunction

endpackage

// File: rtl/core/cdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_ctrl
// Valid bits and ready chain of the four-stage pipeline; bubbles collapse.
// ----------------------------------------------------------------------------
module cdc_ctrl
	import cdc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_ready,
	output cdc_ctl_t ctl
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = ~v_s4 | out_ready;
	assign rdy3 = ~v_s3 | rdy4;
	assign rdy2 = ~v_s2 | rdy3;
	assign rdy1 = ~v_s1 | rdy2;

	always_comb begin
		ctl.en1       = rdy1 & in_valid;
		ctl.en2       = rdy2 & v_s1;
		ctl.en3       = rdy3 & v_s2;
		ctl.en4       = rdy4 & v_s3;
		ctl.in_ready  = rdy1;
		ctl.out_valid = v_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

endmodule

// File: rtl/core/cdc_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_date
// Three pipeline stages for one date: validity, ordinal day number, weekday.
// ----------------------------------------------------------------------------
module cdc_date
	import cdc_pkg::*;
#(
	parameter int unsigned YEAR_MAX = YEAR_MAX_DEF
) (
	input  logic               clk,
	input  cdc_ctl_t           ctl,
	input  logic [DAY_W-1:0]   day,
	input  logic [MONTH_W-1:0] month,
	input  logic [YEAR_W-1:0]  year,
	output logic               ok,
	output logic [ORD_W-1:0]   ord,
	output logic [WDAY_W-1:0]  wday
);

	// stage 1: range checks, March-based month, reciprocal products
	logic               early;
	logic [YEAR_W-1:0]  prev_y, zel_y;
	logic [MONTH_W-1:0] zel_m;
	logic               rok_s1;
	logic [DAY_W-1:0]   d_s1;
	logic [MONTH_W-1:0] m_s1, zm_s1;
	logic [YEAR_W-1:0]  y_s1, p_s1, zy_s1;
	logic [PROD_W-1:0]  py_s1, pp_s1, pz_s1;

	assign early  = (month < MON_MAR);
	assign prev_y = year - YEAR_W'(1);
	assign zel_y  = early ? prev_y : year;
	assign zel_m  = early ? (month + MONTHS) : month;

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			rok_s1 <= (year != '0) && (32'(year) <= YEAR_MAX) && (month >= MON_JAN)
				&& (month <= MON_DEC) && (day != '0);
			d_s1   <= day;
			m_s1   <= month;
			zm_s1  <= zel_m;
			y_s1   <= year;
			p_s1   <= prev_y;
			zy_s1  <= zel_y;
			py_s1  <= PROD_W'(year) * PROD_W'(RECIP100);
			pp_s1  <= PROD_W'(prev_y) * PROD_W'(RECIP100);
			pz_s1  <= PROD_W'(zel_y) * PROD_W'(RECIP100);
		end
	end

	// stage 2: quotients, leap year, validity, partial sums
	logic [QUO_W-1:0]  qy, qp, qz;
	logic [6:0]        ry, rz;
	logic              leap;
	logic              ok_s2;
	logic [ORD_W-1:0]  base_s2;
	logic [9:0]        off_s2;
	logic [ZSUM_W-1:0] zsum_s2;

	assign qy   = py_s1[RECIP_SH +: QUO_W];
	assign qp   = pp_s1[RECIP_SH +: QUO_W];
	assign qz   = pz_s1[RECIP_SH +: QUO_W];
	assign ry   = 7'(y_s1 - YEAR_W'(qy) * YEAR_W'(100));
	assign rz   = 7'(zy_s1 - YEAR_W'(qz) * YEAR_W'(100));
	assign leap = (y_s1[1:0] == 2'd0) && ((ry != 7'd0) || (qy[1:0] == 2'd0));

	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			ok_s2   <= rok_s1 && (d_s1 <= month_len(m_s1, leap));
			base_s2 <= ORD_W'(p_s1) * ORD_W'(365) + ORD_W'(p_s1[YEAR_W-1:2])
				- ORD_W'(qp) + ORD_W'(qp[QUO_W-1:2]);
			off_s2  <= 10'(days_before(m_s1)) + 10'(leap && (m_s1 > MON_FEB))
				+ 10'(d_s1);
			zsum_s2 <= ZSUM_W'(d_s1) + ZSUM_W'(zeller_month(zm_s1)) + ZSUM_W'(rz)
				+ ZSUM_W'(rz[6:2]) + ZSUM_W'(qz[QUO_W-1:2]) + ZSUM_W'(qz) * ZSUM_W'(5);
		end
	end

	// stage 3: final ordinal and weekday
	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			ok   <= ok_s2;
			ord  <= base_s2 + ORD_W'(off_s2);
			wday <= ok_s2 ? mod7(zsum_s2) : WDAY_SAT;
		end
	end

endmodule

// File: rtl/core/calendar_date_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_calculator
// Gregorian date check, day distance and Zeller weekday for two dates.
// ----------------------------------------------------------------------------
// Usage:
//   One input transaction on s_axis carries two dates; one output transaction
//   on m_axis carries the validity flags, the absolute day distance (zero if
//   either date is invalid) and the weekday of each date (0 Saturday through
//   6 Friday, zero for an invalid date).
//   From input transaction to output transaction the data passes three
//   stages per date (checks and reciprocal products, quotients and partial
//   sums, ordinal and mod 7) and one stage for the distance and output
//   register. Throughput is one transaction per cycle unless m_axis_tready
//   stalls the output; the four stage registers set it.
//   When m_axis_tready is low the pipeline keeps filling its empty stages and
//   s_axis_tready drops only once all four stages hold a result.
//   Reset clears all stage valid bits; nothing else needs initializing.
// ----------------------------------------------------------------------------
module calendar_date_calculator
	import cdc_pkg::*;
#(
	parameter int unsigned YEAR_MAX = YEAR_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// day_a, month_a, year_a, day_b, month_b, year_b, zero fill
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// valid_a, valid_b, day_distance, weekday_a, weekday_b, zero fill
	output logic [OUT_W-1:0] m_axis_tdata
);

	cdc_ctl_t ctl;

	logic               ok_a, ok_b;
	logic [ORD_W-1:0]   ord_a, ord_b;
	logic [WDAY_W-1:0]  wd_a, wd_b;
	logic               valid_a_s4, valid_b_s4;
	logic [DIST_W-1:0]  dist_s4;
	logic [WDAY_W-1:0]  wd_a_s4, wd_b_s4;
	logic [ORD_W-1:0]   diff;

	cdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	cdc_date #(.YEAR_MAX(YEAR_MAX)) u_date_a (
		.clk   (clk),
		.ctl   (ctl),
		.day   (s_axis_tdata[4:0]),
		.month (s_axis_tdata[8:5]),
		.year  (s_axis_tdata[22:9]),
		.ok    (ok_a),
		.ord   (ord_a),
		.wday  (wd_a)
	);

	cdc_date #(.YEAR_MAX(YEAR_MAX)) u_date_b (
		.clk   (clk),
		.ctl   (ctl),
		.day   (s_axis_tdata[27:23]),
		.month (s_axis_tdata[31:28]),
		.year  (s_axis_tdata[45:32]),
		.ok    (ok_b),
		.ord   (ord_b),
		.wday  (wd_b)
	);

	assign diff = (ord_a > ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);

	always_ff @(posedge clk) begin
		if (ctl.en4) begin
			valid_a_s4 <= ok_a;
			valid_b_s4 <= ok_b;
			dist_s4    <= (ok_a && ok_b) ? diff[DIST_W-1:0] : '0;
			wd_a_s4    <= wd_a;
			wd_b_s4    <= wd_b;
		end
	end

	assign s_axis_tready = ctl.in_ready;
	assign m_axis_tvalid = ctl.out_valid;
	assign m_axis_tdata  = {2'b00, wd_b_s4, wd_a_s4, dist_s4, valid_b_s4, valid_a_s4};

	// invalid date a gives weekday_a zero
	a_wday_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[26:24] == WDAY_SAT)
		else $error("weekday_a nonzero for invalid date");

	// either date invalid forces zero distance
	a_dist_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !(m_axis_tdata[0] && m_axis_tdata[1])
			|-> m_axis_tdata[23:2] == '0)
		else $error("nonzero distance with invalid date");

	// weekdays stay below seven
	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[26:24] != 3'd7) && (m_axis_tdata[29:27] != 3'd7))
		else $error("weekday out of range");

	// input stalls only with a full pipeline
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while pipeline can advance");

endmodule

// File: tb/calendar_date_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_calculator_tb
// Self-checking bench for the two-date Gregorian calculator. A driver sends
// date pairs from a queue with random gaps. The expected flags, day distance
// (from ordinal day numbers) and Zeller weekdays are computed when each input
// transaction is accepted. A monitor stalls at random, holds off once for a
// long stretch, and checks every output transaction field by field.
// ----------------------------------------------------------------------------
module calendar_date_calculator_tb;
	import cdc_pkg::*;

	// lowest field last
	typedef struct packed {
		logic [YEAR_W-1:0]  year_b;
		logic [MONTH_W-1:0] month_b;
		logic [DAY_W-1:0]   day_b;
		logic [YEAR_W-1:0]  year_a;
		logic [MONTH_W-1:0] month_a;
		logic [DAY_W-1:0]   day_a;
	} date_pair_t;

	typedef struct packed {
		logic [WDAY_W-1:0] weekday_b;
		logic [WDAY_W-1:0] weekday_a;
		logic [DIST_W-1:0] day_distance;
		logic              valid_b;
		logic              valid_a;
	} date_result_t;

	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AT      = 400;
	localparam int RANDOM_PAIRS = 1600;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// day_a, month_a, year_a, day_b, month_b, year_b, zero fill
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// valid_a, valid_b, day_distance, weekday_a, weekday_b, zero fill
	logic [OUT_W-1:0]  m_axis_tdata;

	date_pair_t   pending_pairs[$];
	date_result_t expected_results[$];
	int           pairs_total;
	int           pairs_taken = 0;
	int           results_seen = 0;
	int           error_count = 0;
	int           send_gap = 0;
	bit           send_quiet = 1'b0;
	int           recv_stall = 0;
	int           recv_hold = 0;
	bit           recv_quiet = 1'b0;
	date_result_t got_result;
	date_result_t want_result;

	calendar_date_calculator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic bit leap_year(int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic bit real_date(int unsigned d, int unsigned m, int unsigned y);
		return y >= 1 && y <= YEAR_MAX_DEF && m >= 1 && m <= MONTHS && d >= 1
			&& d <= days_in_month(m, y);
	endfunction

	// 1 January of year 1 is day 1
	function automatic int unsigned day_number(int unsigned d, int unsigned m,
			int unsigned y);
		int unsigned p;
		int unsigned n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400 + d;
		for (int unsigned i = 1; i < m; i++)
			n += days_in_month(i, y);
		return n;
	endfunction

	function automatic logic [WDAY_W-1:0] zeller_weekday(int unsigned d, int unsigned m,
			int unsigned y);
		int unsigned k;
		int unsigned j;
		if (m < MON_MAR) begin
			m += 12;
			y -= 1;
		end
		k = y % 100;
		j = y / 100;
		return WDAY_W'((d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
	endfunction

	function automatic date_result_t predict_dates(date_pair_t p);
		date_result_t r;
		int unsigned  na;
		int unsigned  nb;
		r = '0;
		r.valid_a = real_date(p.day_a, p.month_a, p.year_a);
		r.valid_b = real_date(p.day_b, p.month_b, p.year_b);
		r.weekday_a = r.valid_a ? zeller_weekday(p.day_a, p.month_a, p.year_a) : WDAY_SAT;
		r.weekday_b = r.valid_b ? zeller_weekday(p.day_b, p.month_b, p.year_b) : WDAY_SAT;
		if (r.valid_a && r.valid_b) begin
			na = day_number(p.day_a, p.month_a, p.year_a);
			nb = day_number(p.day_b, p.month_b, p.year_b);
			r.day_distance = DIST_W'((na > nb) ? na - nb : nb - na);
		end
		return r;
	endfunction

	task automatic add_pair(int unsigned da, int unsigned ma, int unsigned ya,
			int unsigned db, int unsigned mb, int unsigned yb);
		date_pair_t p;
		p.day_a   = DAY_W'(da);
		p.month_a = MONTH_W'(ma);
		p.year_a  = YEAR_W'(ya);
		p.day_b   = DAY_W'(db);
		p.month_b = MONTH_W'(mb);
		p.year_b  = YEAR_W'(yb);
		pending_pairs.push_back(p);
	endtask

	// mostly well-formed dates, some near month ends and some raw noise
	task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
			output logic [YEAR_W-1:0] y);
		int unsigned len;
		int unsigned pick;
		if ($urandom_range(0, 99) < 12) begin
			d = DAY_W'($urandom);
			m = MONTH_W'($urandom);
			y = YEAR_W'($urandom);
		end else begin
			case ($urandom_range(0, 9))
				0:       y = YEAR_W'($urandom_range(0, 1) ? $urandom_range(1, 4)
					: $urandom_range(YEAR_MAX_DEF - 3, YEAR_MAX_DEF));
				1:       y = YEAR_W'(100 * $urandom_range(1, 99));
				default: y = YEAR_W'($urandom_range(1, YEAR_MAX_DEF));
			endcase
			m = MONTH_W'($urandom_range(1, 12));
			pick = $urandom_range(0, 19);
			if (pick == 3)
				m = MON_FEB;
			len = days_in_month(m, y);
			case (pick)
				0:       d = DAY_W'(len + 1);
				1:       d = DAY_W'(len);
				2:       d = DAY_W'(1);
				3:       d = DAY_W'(29);
				default: d = DAY_W'($urandom_range(1, len));
			endcase
		end
	endtask

	// driver: also predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(
					predict_dates(date_pair_t'(s_axis_tdata[$bits(date_pair_t)-1:0])));
				pairs_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap--;
				end else if (pending_pairs.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= IN_W'(pending_pairs.pop_front());
					if ($urandom_range(0, 31) == 0)
						send_quiet = !send_quiet;
					send_gap = send_quiet ? 0 : $urandom_range(0, 7);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_result = date_result_t'(m_axis_tdata[$bits(date_result_t)-1:0]);
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("output transaction with nothing expected: %h", m_axis_tdata);
					error_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.valid_a !== want_result.valid_a) begin
						$error("valid_a: expected %0d, got %0d",
							want_result.valid_a, got_result.valid_a);
						error_count++;
					end
					if (got_result.valid_b !== want_result.valid_b) begin
						$error("valid_b: expected %0d, got %0d",
							want_result.valid_b, got_result.valid_b);
						error_count++;
					end
					if (got_result.day_distance !== want_result.day_distance) begin
						$error("day_distance: expected %0d, got %0d",
							want_result.day_distance, got_result.day_distance);
						error_count++;
					end
					if (got_result.weekday_a !== want_result.weekday_a) begin
						$error("weekday_a: expected %0d, got %0d",
							want_result.weekday_a, got_result.weekday_a);
						error_count++;
					end
					if (got_result.weekday_b !== want_result.weekday_b) begin
						$error("weekday_b: expected %0d, got %0d",
							want_result.weekday_b, got_result.weekday_b);
						error_count++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					recv_quiet = !recv_quiet;
				recv_stall = recv_quiet ? 0 : $urandom_range(0, 7);
				// one long back-pressure stretch to fill the pipeline
				if (results_seen == HOLD_AT)
					recv_hold = HOLD_CYCLES;
			end
			if (recv_hold > 0) begin
				m_axis_tready <= 1'b0;
				recv_hold--;
			end else if (recv_stall > 0) begin
				m_axis_tready <= 1'b0;
				recv_stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [DAY_W-1:0]   da;
		logic [MONTH_W-1:0] ma;
		logic [YEAR_W-1:0]  ya;
		logic [DAY_W-1:0]   db;
		logic [MONTH_W-1:0] mb;
		logic [YEAR_W-1:0]  yb;

		// widest span, both orders
		add_pair(1, 1, 1, 31, 12, YEAR_MAX_DEF);
		add_pair(31, 12, YEAR_MAX_DEF, 1, 1, 1);
		// leap rules: by 400, by 100, by 4, common year
		add_pair(29, 2, 2000, 29, 2, 1900);
		add_pair(29, 2, 2024, 28, 2, 2023);
		add_pair(29, 2, 2023, 1, 3, 2023);
		add_pair(1, 1, 2100, 29, 2, 2100);
		add_pair(30, 2, 2000, 1, 3, 2000);
		add_pair(1, 3, 2000, 29, 2, 2000);
		// equal dates
		add_pair(15, 6, 1987, 15, 6, 1987);
		// all-zero and all-ones fields
		add_pair(0, 0, 0, 0, 0, 0);
		add_pair(31, 15, 16383, 31, 15, 16383);
		// year past the limit, month out of range, day zero
		add_pair(1, 1, YEAR_MAX_DEF + 1, 1, 1, YEAR_MAX_DEF);
		add_pair(31, 13, 2020, 31, 12, 2020);
		add_pair(0, 5, 2020, 1, 5, 2020);
		// 30-day month overflow
		add_pair(31, 4, 1999, 30, 4, 1999);
		// Jan/Feb of year 1 push Zeller into year 0
		add_pair(1, 1, 1, 28, 2, 1);
		add_pair(31, 12, 1600, 1, 1, 1601);
		add_pair(31, 1, 2004, 1, 3, 2004);
		add_pair(1, 1, 1, 1, 1, 2);

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			pick_date(da, ma, ya);
			if ($urandom_range(0, 19) == 0) begin
				db = da;
				mb = ma;
				yb = ya;
			end else begin
				pick_date(db, mb, yb);
			end
			add_pair(da, ma, ya, db, mb, yb);
		end
		pairs_total = pending_pairs.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pairs_taken < pairs_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/cdc_pkg.sv
rtl/core/cdc_ctrl.sv
rtl/core/cdc_date.sv
rtl/core/calendar_date_calculator.sv
tb/calendar_date_calculator_tb.sv
